@@ sv/iim_pkg.sv @@
package iim_pkg;

  localparam int PIXEL_W    = 8;
  localparam int WEIGHT_W   = PIXEL_W + 1;
  localparam int IN_TDATA_W = 8;

  localparam int WSUM_W = 29;
  localparam int MSUM_W = 37;
  localparam int IDX_W  = 10;

  localparam int WSUM_LSB = 0;
  localparam int SSUM_LSB = WSUM_LSB + WSUM_W;
  localparam int RSUM_LSB = SSUM_LSB + MSUM_W;
  localparam int CSUM_LSB = RSUM_LSB + MSUM_W;
  localparam int ROW_LSB  = CSUM_LSB + MSUM_W;
  localparam int COL_LSB  = ROW_LSB + IDX_W;
  localparam int OUT_TDATA_W = COL_LSB + IDX_W;

  localparam int WST_W = 19;
  localparam int SST_W = 27;
  localparam int RST_W = 28;
  localparam int CST_W = 29;
  localparam int ENTRY_W = WST_W + SST_W + RST_W + CST_W;

  localparam int WACC_W = 29;
  localparam int SACC_W = 37;
  localparam int RACC_W = 38;
  localparam int CACC_W = 38;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_ROWS = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [CST_W-1:0] colm;
    logic [RST_W-1:0] rowm;
    logic [SST_W-1:0] square;
    logic [WST_W-1:0] weight;
  } column_entry_t;

endpackage

@@ sv/iim_ram.sv @@
module iim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/integral_image_moments_unit.sv @@
// Streaming integral-image unit: grey pixels enter in raster order on the in_ stream and each
// accepted pixel yields one out_ transaction with the four inclusive summed-area values (sum of
// pixel+1, of its square, and of its row- and column-weighted values) at that position, plus the
// position itself; out_tlast marks the last pixel of the frame. The unit sustains one pixel per
// clock unless out_tready stalls it; each pixel is registered in stage 1, stage 2 and the output;
// the rate is set by the single column-sum RAM (MAX_COLS entries of 103 bits), which is read in
// the cycle a pixel is accepted and written back when that pixel leaves stage 1, with the previous
// write forwarded when the same column comes back at once. The image size registers take effect
// for the next pixel and should be changed only between frames; row 0 of each frame writes the
// column sums without using the values read, so no clearing is needed after reset.
module integral_image_moments_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iim_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [28:0] weight_sum, [65:29] square_sum, [102:66] row_moment_sum,
  // [139:103] col_moment_sum, [149:140] row_index, [159:150] col_index
  output logic [iim_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [iim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iim_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import iim_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TRW = RW + WEIGHT_W;
  localparam int TCW = CW + WEIGHT_W;
  localparam int SQW = 2 * WEIGHT_W;

  logic [CFG_DATA_W-1:0] cols_cfg_r, rows_cfg_r;
  logic [CW-1:0]         col_last;
  logic [RW-1:0]         row_last;
  logic [CW-1:0]         col_cnt_r;
  logic [RW-1:0]         row_cnt_r;
  logic                  last_col, last_row;

  logic en1, en2, en3, in_xfer;
  logic v1_r, v2_r, out_valid_r;

  logic [WEIGHT_W-1:0] w0;
  logic [SQW-1:0]      ww0;
  logic [TRW-1:0]      tr0;
  logic [TCW-1:0]      tc0;

  logic [WEIGHT_W-1:0] s1_w_r;
  logic [SQW-1:0]      s1_ww_r;
  logic [TRW-1:0]      s1_tr_r;
  logic [TCW-1:0]      s1_tc_r;
  logic [CW-1:0]       s1_col_r;
  logic [RW-1:0]       s1_row_r;
  logic                s1_first_row_r, s1_end_r;

  column_entry_t ram_q, base, col_t;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [CW-1:0]      fwd_addr_r;
  column_entry_t      fwd_data_r;
  logic               fwd_vld_r;

  column_entry_t s2_t_r;
  logic [CW-1:0] s2_col_r;
  logic [RW-1:0] s2_row_r;
  logic          s2_end_r;

  logic [WACC_W-1:0] wacc_r, wacc_nxt;
  logic [SACC_W-1:0] sacc_r, sacc_nxt;
  logic [RACC_W-1:0] racc_r, racc_nxt;
  logic [CACC_W-1:0] cacc_r, cacc_nxt;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= CFG_SIZE_RESET;
      rows_cfg_r <= CFG_SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_COLS: cols_cfg_r <= cfg_wdata;
        CFG_IMAGE_ROWS: rows_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_r == '0) begin
      col_last = '0;
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(cols_cfg_r - CFG_DATA_W'(1));
    end
    if (rows_cfg_r == '0) begin
      row_last = '0;
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      row_last = RW'(MAX_ROWS - 1);
    end else begin
      row_last = RW'(rows_cfg_r - CFG_DATA_W'(1));
    end
  end

  assign last_col = col_cnt_r >= col_last;
  assign last_row = row_cnt_r >= row_last;

  assign en3       = !out_valid_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_xfer   = in_tvalid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  assign w0  = WEIGHT_W'(in_tdata[PIXEL_W-1:0]) + WEIGHT_W'(1);
  assign ww0 = SQW'(w0) * SQW'(w0);
  assign tr0 = TRW'(row_cnt_r) * TRW'(w0);
  assign tc0 = TCW'(col_cnt_r) * TCW'(w0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_w_r         <= w0;
      s1_ww_r        <= ww0;
      s1_tr_r        <= tr0;
      s1_tc_r        <= tc0;
      s1_col_r       <= col_cnt_r;
      s1_row_r       <= row_cnt_r;
      s1_first_row_r <= row_cnt_r == '0;
      s1_end_r       <= last_col && last_row;
    end
  end

  iim_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (col_t),
    .re    (en1),
    .raddr (col_cnt_r),
    .rdata (ram_rdata)
  );

  assign ram_q  = column_entry_t'(ram_rdata);
  assign ram_we = v1_r && en2;

  always_comb begin
    if (s1_first_row_r) begin
      base = '0;
    end else if (fwd_vld_r && (fwd_addr_r == s1_col_r)) begin
      base = fwd_data_r;
    end else begin
      base = ram_q;
    end
    col_t.weight = base.weight + WST_W'(s1_w_r);
    col_t.square = base.square + SST_W'(s1_ww_r);
    col_t.rowm   = base.rowm + RST_W'(s1_tr_r);
    col_t.colm   = base.colm + CST_W'(s1_tc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (ram_we) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= s1_col_r;
      fwd_data_r <= col_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      s2_t_r   <= col_t;
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
      s2_end_r <= s1_end_r;
    end
  end

  always_comb begin
    if (s2_col_r == '0) begin
      wacc_nxt = WACC_W'(s2_t_r.weight);
      sacc_nxt = SACC_W'(s2_t_r.square);
      racc_nxt = RACC_W'(s2_t_r.rowm);
      cacc_nxt = CACC_W'(s2_t_r.colm);
    end else begin
      wacc_nxt = wacc_r + WACC_W'(s2_t_r.weight);
      sacc_nxt = sacc_r + SACC_W'(s2_t_r.square);
      racc_nxt = racc_r + RACC_W'(s2_t_r.rowm);
      cacc_nxt = cacc_r + CACC_W'(s2_t_r.colm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wacc_r      <= '0;
      sacc_r      <= '0;
      racc_r      <= '0;
      cacc_r      <= '0;
    end else begin
      if (en3) begin
        out_valid_r <= v2_r;
      end
      if (v2_r && en3) begin
        wacc_r <= wacc_nxt;
        sacc_r <= sacc_nxt;
        racc_r <= racc_nxt;
        cacc_r <= cacc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && en3) begin
      out_row_r <= IDX_W'(s2_row_r);
      out_col_r <= IDX_W'(s2_col_r);
      out_end_r <= s2_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_end_r;
  assign out_tdata  = {out_col_r, out_row_r, MSUM_W'(cacc_r), MSUM_W'(racc_r),
                       MSUM_W'(sacc_r), WSUM_W'(wacc_r)};

endmodule

@@ sv/iim_checker.sv @@
module iim_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [iim_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  import iim_pkg::*;

  logic                out_xfer;
  logic                frame_start_r;
  logic [WSUM_W-1:0]   wsum;
  logic [IDX_W-1:0]    row_idx, col_idx;

  assign out_xfer = out_tvalid && out_tready;
  assign wsum     = out_tdata[WSUM_LSB +: WSUM_W];
  assign row_idx  = out_tdata[ROW_LSB +: IDX_W];
  assign col_idx  = out_tdata[COL_LSB +: IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_xfer) begin
      frame_start_r <= out_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && frame_start_r |-> row_idx == '0 && col_idx == '0)
    else $error("frame does not start at the origin");

  a_origin_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && row_idx == '0 && col_idx == '0 |-> wsum != '0 && wsum <= WSUM_W'(256))
    else $error("weight sum at the origin out of pixel range");

endmodule

bind integral_image_moments_unit iim_checker u_iim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ test/tb.sv @@
module tb;
  import iim_pkg::*;

  localparam int MAX_COLS      = 1024;
  localparam int MAX_ROWS      = 1024;
  localparam int COL_AW        = $clog2(MAX_COLS);
  localparam int RANDOM_PIXELS = 850;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [WSUM_W-1:0] weight_sum;
    logic [MSUM_W-1:0] square_sum;
    logic [MSUM_W-1:0] row_moment_sum;
    logic [MSUM_W-1:0] col_moment_sum;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic              frame_end;
  } moments_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  integral_image_moments_unit #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [WST_W-1:0]  col_weight [MAX_COLS];
  logic [SST_W-1:0]  col_square [MAX_COLS];
  logic [RST_W-1:0]  col_rowm   [MAX_COLS];
  logic [CST_W-1:0]  col_colm   [MAX_COLS];
  logic [WACC_W-1:0] run_weight = '0;
  logic [SACC_W-1:0] run_square = '0;
  logic [RACC_W-1:0] run_rowm   = '0;
  logic [CACC_W-1:0] run_colm   = '0;
  int unsigned       cur_row     = 0;
  int unsigned       cur_col     = 0;
  int unsigned       row0_extent = 0;
  logic [CFG_DATA_W-1:0] cols_reg = CFG_SIZE_RESET;
  logic [CFG_DATA_W-1:0] rows_reg = CFG_SIZE_RESET;

  moments_t              moments_due [$];
  logic [IN_TDATA_W-1:0] pixel_q [$];
  int unsigned           pixels_offered  = 0;
  int unsigned           pixels_accepted = 0;
  int unsigned           mismatch_count  = 0;

  logic        in_fire_q     = 1'b0;
  logic        out_fire_q    = 1'b0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int unsigned tx_gap        = 0;
  int unsigned rx_gap        = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned effective_size(input logic [CFG_DATA_W-1:0] v,
                                                 input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned ncols, nrows, n;
    ncols = effective_size(cols_reg, MAX_COLS);
    nrows = effective_size(rows_reg, MAX_ROWS);
    n = (cur_col + 1 >= ncols) ? 1 : ncols - cur_col;
    if (cur_row + 1 < nrows) n += (nrows - cur_row - 1) * ncols;
    return n;
  endfunction

  function automatic int unsigned idle_draw(input bit enabled);
    return enabled ? $urandom_range(0, 16) : 0;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return IN_TDATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic accumulate_pixel(input logic [PIXEL_W-1:0] pixel);
    int unsigned ncols, nrows;
    bit last_col, last_row;
    logic [WEIGHT_W-1:0] w;
    logic [WST_W-1:0] tw;
    logic [SST_W-1:0] ts;
    logic [RST_W-1:0] tr;
    logic [CST_W-1:0] tc;
    moments_t m;
    ncols = effective_size(cols_reg, MAX_COLS);
    nrows = effective_size(rows_reg, MAX_ROWS);
    last_col = (cur_col + 1 >= ncols);
    last_row = (cur_row + 1 >= nrows);
    w  = {1'b0, pixel} + WEIGHT_W'(1);
    tw = WST_W'(w);
    ts = SST_W'(w) * SST_W'(w);
    tr = RST_W'(cur_row * w);
    tc = CST_W'(cur_col * w);
    if (cur_row != 0) begin
      tw = tw + col_weight[cur_col[COL_AW-1:0]];
      ts = ts + col_square[cur_col[COL_AW-1:0]];
      tr = tr + col_rowm[cur_col[COL_AW-1:0]];
      tc = tc + col_colm[cur_col[COL_AW-1:0]];
    end else begin
      row0_extent = (cur_col == 0 || cur_col + 1 > row0_extent) ? cur_col + 1 : row0_extent;
    end
    col_weight[cur_col[COL_AW-1:0]] = tw;
    col_square[cur_col[COL_AW-1:0]] = ts;
    col_rowm[cur_col[COL_AW-1:0]]   = tr;
    col_colm[cur_col[COL_AW-1:0]]   = tc;
    if (cur_col == 0) begin
      run_weight = '0;
      run_square = '0;
      run_rowm   = '0;
      run_colm   = '0;
    end
    run_weight = run_weight + WACC_W'(tw);
    run_square = run_square + SACC_W'(ts);
    run_rowm   = run_rowm + RACC_W'(tr);
    run_colm   = run_colm + CACC_W'(tc);
    m.weight_sum     = run_weight;
    m.square_sum     = run_square;
    m.row_moment_sum = run_rowm[MSUM_W-1:0];
    m.col_moment_sum = run_colm[MSUM_W-1:0];
    m.row_index      = cur_row[IDX_W-1:0];
    m.col_index      = cur_col[IDX_W-1:0];
    m.frame_end      = last_col && last_row;
    moments_due = {moments_due, m};
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic compare_moments();
    moments_t want;
    if (moments_due.size() == 0) begin
      flag_mismatch("unexpected transaction", 64'd0, 64'(out_tdata[WSUM_LSB +: WSUM_W]));
    end else begin
      want = moments_due.pop_front();
      if (out_tdata[WSUM_LSB +: WSUM_W] !== want.weight_sum)
        flag_mismatch("weight_sum", 64'(want.weight_sum),
                      64'(out_tdata[WSUM_LSB +: WSUM_W]));
      if (out_tdata[SSUM_LSB +: MSUM_W] !== want.square_sum)
        flag_mismatch("square_sum", 64'(want.square_sum),
                      64'(out_tdata[SSUM_LSB +: MSUM_W]));
      if (out_tdata[RSUM_LSB +: MSUM_W] !== want.row_moment_sum)
        flag_mismatch("row_moment_sum", 64'(want.row_moment_sum),
                      64'(out_tdata[RSUM_LSB +: MSUM_W]));
      if (out_tdata[CSUM_LSB +: MSUM_W] !== want.col_moment_sum)
        flag_mismatch("col_moment_sum", 64'(want.col_moment_sum),
                      64'(out_tdata[CSUM_LSB +: MSUM_W]));
      if (out_tdata[ROW_LSB +: IDX_W] !== want.row_index)
        flag_mismatch("row_index", 64'(want.row_index),
                      64'(out_tdata[ROW_LSB +: IDX_W]));
      if (out_tdata[COL_LSB +: IDX_W] !== want.col_index)
        flag_mismatch("col_index", 64'(want.col_index),
                      64'(out_tdata[COL_LSB +: IDX_W]));
      if (out_tlast !== want.frame_end)
        flag_mismatch("frame_end", 64'(want.frame_end), 64'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    in_fire_q  <= rst_n && in_tvalid && in_tready;
    out_fire_q <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      compare_moments();
    end
    if (rst_n && in_tvalid && in_tready) begin
      accumulate_pixel(in_tdata[PIXEL_W-1:0]);
      pixels_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_fire_q) begin
      if (in_fire_q) tx_gap = idle_draw(tx_idle_en);
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_tdata  <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (out_fire_q) rx_gap = idle_draw(rx_idle_en);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  task automatic offer(input logic [IN_TDATA_W-1:0] p);
    pixel_q = {pixel_q, p};
    pixels_offered++;
  endtask

  task automatic wait_idle();
    while (pixels_accepted != pixels_offered || moments_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_COLS) cols_reg = val;
    else rows_reg = val;
  endtask

  initial begin
    int unsigned n, frame, random_count, phase;
    bit pressure;
    logic [CFG_DATA_W-1:0] cols_val, rows_val;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes, then shrink the columns and rows in the middle of a frame.
    @(posedge clk);
    offer(8'd0);
    offer(8'd255);
    offer(8'd128);
    offer(8'd1);
    offer(8'd254);
    offer(8'h55);
    offer(8'hAA);
    wait_idle();
    set_size(CFG_IMAGE_COLS, 11'd3);
    set_size(CFG_IMAGE_ROWS, 11'd2047);
    @(posedge clk);
    offer(8'd255);
    offer(8'd255);
    offer(8'd0);
    offer(8'd255);
    offer(8'd0);
    wait_idle();
    set_size(CFG_IMAGE_ROWS, 11'd2);
    @(posedge clk);
    n = pixels_to_frame_end();
    repeat (n) offer(8'd255);
    wait_idle();
    set_size(CFG_IMAGE_COLS, 11'd0);
    set_size(CFG_IMAGE_ROWS, 11'd0);
    @(posedge clk);
    offer(8'd255);
    offer(8'd0);
    offer(8'd255);
    wait_idle();
    set_size(CFG_IMAGE_COLS, 11'd2047);
    set_size(CFG_IMAGE_ROWS, 11'd1);
    @(posedge clk);
    repeat (4) offer(random_pixel());
    wait_idle();
    set_size(CFG_IMAGE_COLS, 11'd2);
    @(posedge clk);
    offer(8'd0);
    wait_idle();
    set_size(CFG_IMAGE_COLS, 11'd1);
    set_size(CFG_IMAGE_ROWS, 11'd1024);
    @(posedge clk);
    repeat (4) offer(8'd255);
    wait_idle();

    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: cols_val = 11'd0;
        1: cols_val = CFG_DATA_W'($urandom_range(1025, 2047));
        2: cols_val = CFG_DATA_W'($urandom_range(13, 64));
        default: cols_val = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      // Past row 0 the columns may only grow as far as row 0 of this frame has written.
      if (cur_row != 0 && effective_size(cols_val, MAX_COLS) > row0_extent)
        cols_val = CFG_DATA_W'($urandom_range(1, row0_extent));
      case ($urandom_range(0, 9))
        0: rows_val = 11'd0;
        1: rows_val = CFG_DATA_W'($urandom_range(1025, 2047));
        2: rows_val = CFG_DATA_W'($urandom_range(13, 64));
        default: rows_val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      set_size(CFG_IMAGE_COLS, cols_val);
      set_size(CFG_IMAGE_ROWS, rows_val);
      frame = effective_size(cols_val, MAX_COLS) * effective_size(rows_val, MAX_ROWS);
      if (frame > 128) begin
        n = $urandom_range(1, 30);
      end else begin
        case ($urandom_range(0, 2))
          0: n = $urandom_range(1, pixels_to_frame_end());
          1: n = pixels_to_frame_end();
          default: n = pixels_to_frame_end() + frame * $urandom_range(1, 2);
        endcase
      end
      pressure = (phase % 12 == 1);
      if (pressure && n < 40) n = 40;
      @(posedge clk);
      tx_idle_en = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (pressure) hold_requests++;
      repeat (n) offer(random_pixel());
      random_count += n;
      phase++;
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && moments_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
